/* design/asn_pkg.sv */
package asn_pkg;

    // Internal word: signed, 32 fraction bits, held within +-(2^62 - 1)
    typedef logic signed [63:0] w_t;
    typedef logic [61:0] mag_t;

    localparam w_t W_LIMIT  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam w_t FRAC_ONE = 64'sh0000_0001_0000_0000;

    // Unit latencies in cycles
    localparam int MUL_LAT  = 4;
    localparam int DIV_LAT  = 64;
    localparam int SQRT_LAT = 48;

    // Configuration register indexes
    localparam logic [2:0] REG_CURV   = 3'd0;
    localparam logic [2:0] REG_CONIC  = 3'd1;
    localparam logic [2:0] REG_C2_4   = 3'd2;
    localparam logic [2:0] REG_C6_8   = 3'd3;
    localparam logic [2:0] REG_C10_12 = 3'd4;
    localparam logic [2:0] REG_C14_16 = 3'd5;

    // Saturating add to the internal bound
    function automatic w_t fadd(input w_t a, input w_t b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(W_LIMIT))
            fadd = W_LIMIT;
        else if (s < -65'(W_LIMIT))
            fadd = -W_LIMIT;
        else
            fadd = s[63:0];
    endfunction

    // Clamp to a signed 32-bit result
    function automatic logic [31:0] sat32(input w_t v);
        if (v > 64'sd2147483647)
            sat32 = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            sat32 = 32'h8000_0000;
        else
            sat32 = v[31:0];
    endfunction

    // Sag leaves as W / 2^8, truncated toward zero
    function automatic logic [31:0] sag_out(input w_t v);
        w_t t;
        t = (v + ((v < 0) ? 64'sd255 : 64'sd0)) >>> 8;
        sag_out = sat32(t);
    endfunction

    // Normal part leaves as W / 2^2, truncated toward zero, optional negate
    function automatic logic [31:0] nrm_out(input w_t v, input logic flip);
        w_t n;
        w_t t;
        n = flip ? -v : v;
        t = (n + ((n < 0) ? 64'sd3 : 64'sd0)) >>> 2;
        nrm_out = sat32(t);
    endfunction

endpackage

/* design/asn_delay.sv */
module asn_delay #(
    parameter int W = 64,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] dly_reg [N];

    // Shift line, frozen while the pipeline is held
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign q = dly_reg[N-1];

endmodule

/* design/asn_mul.sv */
module asn_mul import asn_pkg::*; (
    input  logic clk,
    input  logic en,
    input  w_t   a,
    input  w_t   b,
    output w_t   p
);

    logic         neg1_reg, neg2_reg, neg3_reg;
    mag_t         ma_reg, mb_reg, ma_next, mb_next;
    logic [61:0]  pll_reg, plh_reg, phl_reg, phh_reg;
    logic [61:0]  pll_next, plh_next, phl_next, phh_next;
    logic [123:0] prod_reg, prod_next;
    logic [61:0]  r;
    w_t           p_reg, p_next;

    // Stage 1: magnitudes; stage 2: 31x31 partial products
    always_comb
    begin
        ma_next  = a[63] ? mag_t'(-a) : a[61:0];
        mb_next  = b[63] ? mag_t'(-b) : b[61:0];
        pll_next = 62'(ma_reg[30:0]) * 62'(mb_reg[30:0]);
        plh_next = 62'(ma_reg[30:0]) * 62'(mb_reg[61:31]);
        phl_next = 62'(ma_reg[61:31]) * 62'(mb_reg[30:0]);
        phh_next = 62'(ma_reg[61:31]) * 62'(mb_reg[61:31]);
    end

    // Stage 3: sum; stage 4: truncate, saturate, sign
    always_comb
    begin
        prod_next = {phh_reg, 62'b0}
                  + ((124'(plh_reg) + 124'(phl_reg)) << 31)
                  + 124'(pll_reg);
        r = (prod_reg[123:94] != '0) ? W_LIMIT[61:0] : prod_reg[93:32];
        p_next = neg3_reg ? -w_t'({2'b0, r}) : w_t'({2'b0, r});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a[63] ^ b[63];
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            neg2_reg <= neg1_reg;
            pll_reg  <= pll_next;
            plh_reg  <= plh_next;
            phl_reg  <= phl_next;
            phh_reg  <= phh_next;
            neg3_reg <= neg2_reg;
            prod_reg <= prod_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* design/asn_div.sv */
module asn_div import asn_pkg::*; (
    input  logic clk,
    input  logic en,
    input  w_t   a,
    input  w_t   b,
    output w_t   q
);

    localparam int NS = 62;

    logic [61:0] rem_reg  [NS+1];
    logic [61:0] bits_reg [NS+1];
    logic [61:0] quo_reg  [NS+1];
    mag_t        nb_reg   [NS+1];
    logic        neg_reg  [NS+1];
    logic        zero_reg [NS+1];
    logic        ovf_reg  [NS+1];
    mag_t        na, nb;
    w_t          q_reg, q_next;
    logic [61:0] res;

    // Prep: magnitudes, dividend (na << 32) split into head and tail bits
    always_comb
    begin
        na = a[63] ? mag_t'(-a) : a[61:0];
        nb = b[63] ? mag_t'(-b) : b[61:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= 62'(na[61:30]);
            bits_reg[0] <= {na[29:0], 32'b0};
            quo_reg[0]  <= '0;
            nb_reg[0]   <= nb;
            neg_reg[0]  <= a[63] ^ b[63];
            zero_reg[0] <= (a == '0);
            ovf_reg[0]  <= (62'(na[61:30]) >= nb);
        end
    end

    // One quotient bit per stage
    for (genvar i = 1; i <= NS; i++)
    begin : g_step
        logic [62:0] t;
        logic        ge;
        logic [61:0] rem_next;

        always_comb
        begin
            t        = {rem_reg[i-1], bits_reg[i-1][61]};
            ge       = (t >= {1'b0, nb_reg[i-1]});
            rem_next = ge ? 62'(t - {1'b0, nb_reg[i-1]}) : t[61:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                bits_reg[i] <= bits_reg[i-1] << 1;
                quo_reg[i]  <= {quo_reg[i-1][60:0], ge};
                nb_reg[i]   <= nb_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                ovf_reg[i]  <= ovf_reg[i-1];
            end
        end
    end

    // Final: zero dividend, overflow clamp, sign
    always_comb
    begin
        if (zero_reg[NS])
            res = '0;
        else if (ovf_reg[NS])
            res = W_LIMIT[61:0];
        else
            res = quo_reg[NS];
        q_next = neg_reg[NS] ? -w_t'({2'b0, res}) : w_t'({2'b0, res});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* design/asn_sqrt.sv */
module asn_sqrt import asn_pkg::*; (
    input  logic clk,
    input  logic en,
    input  w_t   v,
    output w_t   root
);

    localparam int NS = 47;

    logic [93:0] bits_reg [NS+1];
    logic [48:0] rem_reg  [NS+1];
    logic [46:0] root_reg [NS+1];

    // Prep: radicand is v << 32, zero for non-positive input
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bits_reg[0] <= (v > 0) ? {v[61:0], 32'b0} : '0;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // One root bit per stage, two radicand bits consumed
    for (genvar i = 1; i <= NS; i++)
    begin : g_step
        logic [50:0] t;
        logic [50:0] trial;
        logic        ge;
        logic [48:0] rem_next;

        always_comb
        begin
            t        = {rem_reg[i-1], bits_reg[i-1][93:92]};
            trial    = {2'b0, root_reg[i-1], 2'b01};
            ge       = (t >= trial);
            rem_next = ge ? 49'(t - trial) : t[48:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                bits_reg[i] <= bits_reg[i-1] << 2;
                rem_reg[i]  <= rem_next;
                root_reg[i] <= {root_reg[i-1][45:0], ge};
            end
        end
    end

    assign root = w_t'({17'b0, root_reg[NS]});

endmodule

/* design/asn_step.sv */
module asn_step import asn_pkg::*; #(
    parameter int J = 1
) (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] coef,
    input  w_t          u_in,
    input  w_t          pw_in,
    input  w_t          poly_in,
    input  w_t          dpoly_in,
    output w_t          u_out,
    output w_t          pw_out,
    output w_t          poly_out,
    output w_t          dpoly_out
);

    localparam int STEP_LAT = 2 * MUL_LAT + 1;
    localparam w_t DMUL     = w_t'(2 * J);

    w_t a_w, a2_w;
    w_t pw_new, term, dterm, dterm_d, poly_d, dpoly_d;
    w_t poly_sum, dpoly_sum;

    // Coefficient and its derivative weight 2J
    always_comb
    begin
        a_w  = w_t'($signed(coef)) <<< 8;
        a2_w = a_w * DMUL;
    end

    // pw' = pw * u, then a * pw'; derivative term uses the old power
    asn_mul u_mul_pw    (.clk(clk), .en(en), .a(pw_in), .b(u_in),  .p(pw_new));
    asn_mul u_mul_term  (.clk(clk), .en(en), .a(a_w),   .b(pw_new), .p(term));
    asn_mul u_mul_dterm (.clk(clk), .en(en), .a(a2_w),  .b(pw_in), .p(dterm));

    asn_delay #(.W(64), .N(MUL_LAT)) u_dly_dterm
        (.clk(clk), .en(en), .d(dterm), .q(dterm_d));
    asn_delay #(.W(64), .N(2 * MUL_LAT)) u_dly_poly
        (.clk(clk), .en(en), .d(poly_in), .q(poly_d));
    asn_delay #(.W(64), .N(2 * MUL_LAT)) u_dly_dpoly
        (.clk(clk), .en(en), .d(dpoly_in), .q(dpoly_d));

    // Accumulate the term and the derivative term into their running sums
    always_comb
    begin
        poly_sum  = fadd(poly_d, term);
        dpoly_sum = fadd(dpoly_d, dterm_d);
    end

    asn_delay #(.W(64), .N(1)) u_reg_poly
        (.clk(clk), .en(en), .d(poly_sum), .q(poly_out));
    asn_delay #(.W(64), .N(1)) u_reg_dpoly
        (.clk(clk), .en(en), .d(dpoly_sum), .q(dpoly_out));

    asn_delay #(.W(64), .N(STEP_LAT)) u_dly_u
        (.clk(clk), .en(en), .d(u_in), .q(u_out));
    asn_delay #(.W(64), .N(STEP_LAT - MUL_LAT)) u_dly_pw
        (.clk(clk), .en(en), .d(pw_new), .q(pw_out));

endmodule

/* design/aspheric_surface_sag_normal_core.sv */
// Even-asphere sag and unit normal, fully pipelined.
// The time from input transaction to result is set by the chain of u and D,
// radicand sqrt, slope divider and sum, normal length, length sqrt,
// normalizing divider and the output register.
// Throughput: one transaction per cycle; a held output freezes the whole pipe.
// Reset: rst_n (async, low) clears valid bits and configuration registers.
module aspheric_surface_sag_normal_core import asn_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] x_norm,
    input  logic signed [31:0] y_norm,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sag_norm,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic               domain_error
);

    // Timeline (cycle at which each value is registered)
    localparam int T_U    = MUL_LAT + 1;
    localparam int T_KC   = 2 * MUL_LAT;
    localparam int T_D    = 3 * MUL_LAT + 1;
    localparam int T_SD   = T_D + SQRT_LAT;
    localparam int T_P    = T_U + 8 * (2 * MUL_LAT + 1);
    localparam int T_SQ   = T_SD + 1 + DIV_LAT;
    localparam int T_G    = T_SD + DIV_LAT + 1;
    localparam int T_SAG  = T_SQ + 1;
    localparam int T_S1   = T_G + 2 * MUL_LAT + 2;
    localparam int T_LEN  = T_S1 + SQRT_LAT;
    localparam int T_N    = T_LEN + DIV_LAT;
    localparam int LAT    = T_N + 1;

    logic [31:0] curv_reg, conic_reg;
    logic [63:0] coef_reg [4];
    logic [LAT-1:0] vld_reg;
    logic        en;

    w_t x_w, y_w, c_w, k_w;
    w_t xx, yy, u, cc, opk_sum, opk, u_d3, kc, dp, d_sum, d, sd;
    w_t u_s [9];
    w_t pw_s [9];
    w_t poly_s [9];
    w_t dpoly_s [9];
    w_t cu, cu_d, opsd_sum, opsd, sagq, gq, dpoly_d, g_sum, g, poly_d, sag_sum, sag;
    w_t x_d, y_d, px, py, sxx, syy, s_sum, s, s1_sum, s1, len, px_d, py_d;
    w_t qx, qy, qz, sag_d;
    w_t uu_sum;
    logic dom, dom_d;

    logic signed [31:0] sag_reg, nx_reg, ny_reg, nz_reg;
    logic               dom_reg;

    // Global advance: the pipe moves unless a finished result is held
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curv_reg  <= '0;
            conic_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CURV:   curv_reg    <= cfg_data[31:0];
                REG_CONIC:  conic_reg   <= cfg_data[31:0];
                REG_C2_4:   coef_reg[0] <= cfg_data;
                REG_C6_8:   coef_reg[1] <= cfg_data;
                REG_C10_12: coef_reg[2] <= cfg_data;
                REG_C14_16: coef_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Operand scaling into the internal format
    always_comb
    begin
        x_w = w_t'(x_norm) <<< 2;
        y_w = w_t'(y_norm) <<< 2;
        c_w = w_t'($signed(curv_reg)) <<< 8;
        k_w = w_t'($signed(conic_reg)) <<< 8;
    end

    // u = x^2 + y^2
    asn_mul u_mul_xx (.clk(clk), .en(en), .a(x_w), .b(x_w), .p(xx));
    asn_mul u_mul_yy (.clk(clk), .en(en), .a(y_w), .b(y_w), .p(yy));
    assign uu_sum = fadd(xx, yy);
    asn_delay #(.W(64), .N(1)) u_reg_u (.clk(clk), .en(en), .d(uu_sum), .q(u));

    // D = 1 - (1 + k) c^2 u
    asn_mul u_mul_cc (.clk(clk), .en(en), .a(c_w), .b(c_w), .p(cc));
    assign opk_sum = fadd(FRAC_ONE, k_w);
    asn_delay #(.W(64), .N(MUL_LAT)) u_dly_opk
        (.clk(clk), .en(en), .d(opk_sum), .q(opk));
    asn_mul u_mul_kc (.clk(clk), .en(en), .a(opk), .b(cc), .p(kc));
    asn_delay #(.W(64), .N(T_KC - T_U)) u_dly_u3
        (.clk(clk), .en(en), .d(u), .q(u_d3));
    asn_mul u_mul_dp (.clk(clk), .en(en), .a(kc), .b(u_d3), .p(dp));
    assign d_sum = fadd(FRAC_ONE, -dp);
    asn_delay #(.W(64), .N(1)) u_reg_d (.clk(clk), .en(en), .d(d_sum), .q(d));
    assign dom = d[63];

    asn_sqrt u_sqrt_d (.clk(clk), .en(en), .v(d), .root(sd));

    // Power series: eight chained terms
    assign u_s[0]     = u;
    assign pw_s[0]    = FRAC_ONE;
    assign poly_s[0]  = '0;
    assign dpoly_s[0] = '0;

    for (genvar j = 1; j <= 8; j++)
    begin : g_term
        logic [31:0] coef;
        if (j % 2 == 1)
        begin : g_lo
            assign coef = coef_reg[(j-1)/2][31:0];
        end
        else
        begin : g_hi
            assign coef = coef_reg[(j-1)/2][63:32];
        end

        asn_step #(.J(j)) u_step (
            .clk(clk), .en(en), .coef(coef),
            .u_in(u_s[j-1]), .pw_in(pw_s[j-1]),
            .poly_in(poly_s[j-1]), .dpoly_in(dpoly_s[j-1]),
            .u_out(u_s[j]), .pw_out(pw_s[j]),
            .poly_out(poly_s[j]), .dpoly_out(dpoly_s[j])
        );
    end

    // Conic sag term c u / (1 + sqrt D)
    asn_mul u_mul_cu (.clk(clk), .en(en), .a(c_w), .b(u), .p(cu));
    asn_delay #(.W(64), .N(T_SD + 1 - T_U - MUL_LAT)) u_dly_cu
        (.clk(clk), .en(en), .d(cu), .q(cu_d));
    assign opsd_sum = fadd(FRAC_ONE, sd);
    asn_delay #(.W(64), .N(1)) u_reg_opsd
        (.clk(clk), .en(en), .d(opsd_sum), .q(opsd));
    asn_div u_div_sag (.clk(clk), .en(en), .a(cu_d), .b(opsd), .q(sagq));

    // Slope over r: g = c / sqrt D + dpoly
    asn_div u_div_g (.clk(clk), .en(en), .a(c_w), .b(sd), .q(gq));
    asn_delay #(.W(64), .N(T_SD + DIV_LAT - T_P)) u_dly_dpoly
        (.clk(clk), .en(en), .d(dpoly_s[8]), .q(dpoly_d));
    assign g_sum = fadd(gq, dpoly_d);
    asn_delay #(.W(64), .N(1)) u_reg_g (.clk(clk), .en(en), .d(g_sum), .q(g));

    // Sag total
    asn_delay #(.W(64), .N(T_SQ - T_P)) u_dly_poly
        (.clk(clk), .en(en), .d(poly_s[8]), .q(poly_d));
    assign sag_sum = fadd(sagq, poly_d);
    asn_delay #(.W(64), .N(1)) u_reg_sag (.clk(clk), .en(en), .d(sag_sum), .q(sag));

    // Unnormalized normal (sign folded into the output stage)
    asn_delay #(.W(64), .N(T_G)) u_dly_x (.clk(clk), .en(en), .d(x_w), .q(x_d));
    asn_delay #(.W(64), .N(T_G)) u_dly_y (.clk(clk), .en(en), .d(y_w), .q(y_d));
    asn_mul u_mul_px (.clk(clk), .en(en), .a(x_d), .b(g), .p(px));
    asn_mul u_mul_py (.clk(clk), .en(en), .a(y_d), .b(g), .p(py));

    // Length = sqrt(px^2 + py^2 + 1)
    asn_mul u_mul_sxx (.clk(clk), .en(en), .a(px), .b(px), .p(sxx));
    asn_mul u_mul_syy (.clk(clk), .en(en), .a(py), .b(py), .p(syy));
    assign s_sum = fadd(sxx, syy);
    asn_delay #(.W(64), .N(1)) u_reg_s (.clk(clk), .en(en), .d(s_sum), .q(s));
    assign s1_sum = fadd(s, FRAC_ONE);
    asn_delay #(.W(64), .N(1)) u_reg_s1 (.clk(clk), .en(en), .d(s1_sum), .q(s1));
    asn_sqrt u_sqrt_len (.clk(clk), .en(en), .v(s1), .root(len));

    // Normalize
    asn_delay #(.W(64), .N(T_LEN - T_G - MUL_LAT)) u_dly_px
        (.clk(clk), .en(en), .d(px), .q(px_d));
    asn_delay #(.W(64), .N(T_LEN - T_G - MUL_LAT)) u_dly_py
        (.clk(clk), .en(en), .d(py), .q(py_d));
    asn_div u_div_nx (.clk(clk), .en(en), .a(px_d),     .b(len), .q(qx));
    asn_div u_div_ny (.clk(clk), .en(en), .a(py_d),     .b(len), .q(qy));
    asn_div u_div_nz (.clk(clk), .en(en), .a(FRAC_ONE), .b(len), .q(qz));

    asn_delay #(.W(64), .N(T_N - T_SAG)) u_dly_sag
        (.clk(clk), .en(en), .d(sag), .q(sag_d));
    asn_delay #(.W(1), .N(T_N - T_D)) u_dly_dom
        (.clk(clk), .en(en), .d(dom), .q(dom_d));

    // Output register: scale back, domain error zeroes the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dom_reg <= dom_d;
            if (dom_d)
            begin
                sag_reg <= '0;
                nx_reg  <= '0;
                ny_reg  <= '0;
                nz_reg  <= '0;
            end
            else
            begin
                sag_reg <= sag_out(sag_d);
                nx_reg  <= nrm_out(qx, 1'b1);
                ny_reg  <= nrm_out(qy, 1'b1);
                nz_reg  <= nrm_out(qz, 1'b0);
            end
        end
    end

    assign sag_norm     = sag_reg;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_reg;
    assign domain_error = dom_reg;

endmodule

/* design/asn_checker.sv */
module asn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] sag_norm,
    input logic signed [31:0] normal_x,
    input logic signed [31:0] normal_y,
    input logic signed [31:0] normal_z,
    input logic               domain_error
);

    // A held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sag_norm)
            && $stable(normal_x) && $stable(normal_y) && $stable(normal_z))
        else $error("held result changed");

    // Input is only held back by a held result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with no held result");

    // Domain error zeroes the payload
    a_dom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && domain_error |-> sag_norm == 0 && normal_x == 0
            && normal_y == 0 && normal_z == 0)
        else $error("domain error with nonzero payload");

    // Normal z lies in (0, 1]
    a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !domain_error |-> normal_z > 0
            && normal_z <= 32'sh4000_0000)
        else $error("normal z out of range");

endmodule

bind aspheric_surface_sag_normal_core asn_checker u_asn_checker (.*);
